// ===== rtl/plc_pkg.sv =====
`timescale 1ns / 1ps

package plc_pkg;

    localparam int TS_W       = 64;
    localparam int SAMP_W     = 32;
    localparam int PH_FIELD_W = 4;
    localparam int MASK_W     = 11;
    localparam int SAMPLES_W  = 7;

    // duration subtractor works one nibble per cycle
    localparam int DIG_W      = 4;
    localparam int DIG_STEPS  = TS_W / DIG_W;
    localparam int DIG_CNT_W  = $clog2(DIG_STEPS);

    localparam logic [MASK_W-1:0] MASK_RESET = '1;

    typedef enum logic [1:0] {
        OP_BEGIN     = 2'd0,
        OP_END       = 2'd1,
        OP_CLR_PEAK  = 2'd2,
        OP_CLR_ALL   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   operation;
        logic [PH_FIELD_W-1:0] phase;
        logic [TS_W-1:0]       timestamp;
    } req_item_t;

    typedef struct packed {
        logic [PH_FIELD_W-1:0] phase_out;
        logic [SAMP_W-1:0]     last_ticks;
        logic [SAMP_W-1:0]     avg_ticks;
        logic [SAMP_W-1:0]     max_ticks;
        logic [SAMPLES_W-1:0]  samples;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SUB,
        S_RING,
        S_UPD,
        S_DIVINIT,
        S_DIV,
        S_DONE
    } state_t;

endpackage

// ===== rtl/phase_latency_profiler_core.sv =====
`timescale 1ns / 1ps
// Per item: load the phase record; for an end item that takes a sample, run the
//   nibble-serial subtractor, read the sample ring and write back the record; then run
//   the bit-serial divider, skipped for a phase out of range or an empty window; then
//   load the result into the output register. One item at a time: the input stays closed
//   until then, and the load waits while the output register holds an untaken result.
// Reset (rst_n, async, active low): mask to all ones, all phase statistics zero, idle.
module phase_latency_profiler_core #(
    parameter int PHASES = 11,
    parameter int WINDOW = 120
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  plc_pkg::req_item_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output plc_pkg::rsp_item_t            rsp,
    input  logic                          cfg_we,
    input  logic [plc_pkg::MASK_W-1:0]    cfg_wdata
);
    import plc_pkg::*;

    localparam int PH_W      = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    // WINDOW samples of 32 bits never overflow this
    localparam int SUM_W     = SAMP_W + SLOT_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int WIN_DEPTH = PHASES * WINDOW;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    localparam logic [SLOT_W-1:0]    SLOT_LAST  = SLOT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]     WIN_COUNT  = CNT_W'(WINDOW);
    localparam logic [DIG_CNT_W-1:0] DIG_LAST   = DIG_CNT_W'(DIG_STEPS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(SUM_W - 1);

    // ------------------------------------------------------------------
    // Per-phase statistics live in small memories. A valid bit per phase
    // stands in for clearing: a phase whose bit is low reads as all zero.
    // The peak has a valid bit of its own so that a peak clear leaves the
    // rest of the record alone.
    // ------------------------------------------------------------------
    logic [TS_W-1:0]   start_mem [PHASES];
    logic [SAMP_W-1:0] last_mem  [PHASES];
    logic [SAMP_W-1:0] peak_mem  [PHASES];
    logic [SLOT_W-1:0] slot_mem  [PHASES];
    logic              full_mem  [PHASES];
    logic [SUM_W-1:0]  sum_mem   [PHASES];

    // sample ring of every phase, flat: phase * WINDOW + slot
    logic [SAMP_W-1:0] win_mem [WIN_DEPTH];

    state_t state_reg, state_next;

    logic [MASK_W-1:0] mask_reg;
    logic [PHASES-1:0] stat_vld_reg, stat_vld_next;
    logic [PHASES-1:0] peak_vld_reg, peak_vld_next;

    // captured item
    op_t                   op_reg;
    logic [PH_FIELD_W-1:0] ph_reg;
    logic                  ph_ok_reg;
    logic [PH_W-1:0]       idx_reg;

    // registered reads of the phase record
    logic [TS_W-1:0]   rd_start_reg;
    logic [SAMP_W-1:0] rd_last_reg;
    logic [SAMP_W-1:0] rd_peak_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic              rd_full_reg;
    logic [SUM_W-1:0]  rd_sum_reg;
    logic [SAMP_W-1:0] win_rd_reg;

    // nibble-serial subtractor
    logic [TS_W-1:0]      ts_sh_reg;
    logic [TS_W-1:0]      st_sh_reg;
    logic [TS_W-1:0]      diff_reg;
    logic                 borrow_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;

    // working copy of the record
    logic [SAMP_W-1:0] last_w_reg;
    logic [SAMP_W-1:0] peak_w_reg;
    logic [SLOT_W-1:0] slot_w_reg;
    logic              full_w_reg;
    logic [SUM_W-1:0]  sum_w_reg;

    // bit-serial restoring divider; the dividend register fills with the quotient
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    // control strobes from the output decoder
    logic load_rsp;
    logic wr_begin;
    logic wr_end;

    logic            accept;
    logic            req_ph_ok;
    logic [PH_W-1:0] req_idx;

    logic              stat_ok;
    logic              peak_ok;
    logic [TS_W-1:0]   eff_start;
    logic [SAMP_W-1:0] eff_last;
    logic [SAMP_W-1:0] eff_peak;
    logic [SLOT_W-1:0] eff_slot;
    logic              eff_full;
    logic [SUM_W-1:0]  eff_sum;
    logic              ph_on;
    logic              act_begin;
    logic              act_end;

    logic [DIG_W:0]    dig_diff;
    logic [SAMP_W-1:0] sample;
    logic [SAMP_W-1:0] old_val;
    logic [SUM_W-1:0]  sum_upd;
    logic              slot_wrap;
    logic [SLOT_W-1:0] slot_upd;
    logic              full_upd;
    logic [SAMP_W-1:0] peak_upd;
    logic [WIN_AW-1:0] win_addr;
    logic [CNT_W-1:0]  n_cur;
    logic              div_skip;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              trial_ge;
    logic [CNT_W-1:0]  rem_step;

    logic              dig_last;
    logic              div_last;
    logic              rsp_free;

    logic [PHASES-1:0] cfg_fall;
    logic              clr_all_acc;
    logic              clr_peak_acc;

    assign accept    = req_valid && req_ready;
    assign req_ph_ok = 32'(req.phase) < PHASES;
    assign req_idx   = req_ph_ok ? PH_W'(req.phase) : '0;

    // record as it stands after any clear: invalid entries read as zero
    assign stat_ok   = stat_vld_reg[idx_reg];
    assign peak_ok   = peak_vld_reg[idx_reg];
    assign eff_start = stat_ok ? rd_start_reg : '0;
    assign eff_last  = stat_ok ? rd_last_reg  : '0;
    assign eff_slot  = stat_ok ? rd_slot_reg  : '0;
    assign eff_full  = stat_ok ? rd_full_reg  : 1'b0;
    assign eff_sum   = stat_ok ? rd_sum_reg   : '0;
    assign eff_peak  = peak_ok ? rd_peak_reg  : '0;

    // a disabled or out-of-range phase ignores begin and end
    assign ph_on     = ph_ok_reg && (32'(ph_reg) < MASK_W) && mask_reg[ph_reg];
    assign act_begin = ph_on && (op_reg == OP_BEGIN);
    assign act_end   = ph_on && (op_reg == OP_END);

    // one nibble of (timestamp - start), low nibble first
    assign dig_diff = {1'b0, ts_sh_reg[DIG_W-1:0]} - {1'b0, st_sh_reg[DIG_W-1:0]}
                    - (DIG_W + 1)'(borrow_reg);

    // saturate the 64-bit duration to 32 bits
    assign sample    = (|diff_reg[TS_W-1:SAMP_W]) ? '1 : diff_reg[SAMP_W-1:0];
    assign old_val   = full_w_reg ? win_rd_reg : '0;
    assign sum_upd   = sum_w_reg - SUM_W'(old_val) + SUM_W'(sample);
    assign slot_wrap = (slot_w_reg == SLOT_LAST);
    assign slot_upd  = slot_wrap ? '0 : slot_w_reg + 1'b1;
    assign full_upd  = full_w_reg | slot_wrap;
    assign peak_upd  = (sample > peak_w_reg) ? sample : peak_w_reg;
    assign win_addr  = WIN_AW'(idx_reg) * WIN_AW'(WINDOW) + WIN_AW'(slot_w_reg);

    assign n_cur     = full_w_reg ? WIN_COUNT : CNT_W'(slot_w_reg);
    assign div_skip  = !ph_ok_reg || (n_cur == '0);

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, n_reg};
    assign trial_ge  = (trial >= {1'b0, n_reg});
    assign rem_step  = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];

    assign dig_last  = (dig_cnt_reg == DIG_LAST);
    assign div_last  = (div_cnt_reg == DIV_LAST);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (act_end)
                    state_next = S_SUB;
                else
                    state_next = S_DIVINIT;
            end
            S_SUB:
            begin
                if (dig_last)
                    state_next = S_RING;
            end
            S_RING:    state_next = S_UPD;
            S_UPD:     state_next = S_DIVINIT;
            S_DIVINIT:
            begin
                if (div_skip)
                    state_next = S_DONE;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the finished item until the output register frees up
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        req_ready = 1'b0;
        load_rsp  = 1'b0;
        wr_begin  = 1'b0;
        wr_end    = 1'b0;
        unique case (state_reg)
            S_IDLE:  req_ready = 1'b1;
            S_LOAD:  wr_begin  = act_begin;
            S_UPD:   wr_end    = 1'b1;
            S_DONE:  load_rsp  = rsp_free;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Valid bits: clear-all and mask bits falling from 1 to 0 drop whole
    // records; a peak clear drops only peaks. Begin/end set record bits, end also peaks.
    // ------------------------------------------------------------------
    assign cfg_fall     = cfg_we ? (PHASES'(mask_reg) & ~PHASES'(cfg_wdata)) : '0;
    assign clr_all_acc  = accept && (req.operation == OP_CLR_ALL);
    assign clr_peak_acc = accept && ((req.operation == OP_CLR_PEAK)
                                     || (req.operation == OP_CLR_ALL));

    always_comb
    begin
        stat_vld_next = stat_vld_reg & ~cfg_fall;
        peak_vld_next = peak_vld_reg & ~cfg_fall;
        if (clr_all_acc)
            stat_vld_next = '0;
        if (clr_peak_acc)
            peak_vld_next = '0;
        if (wr_begin || wr_end)
            stat_vld_next[idx_reg] = 1'b1;
        if (wr_end)
            peak_vld_next[idx_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= MASK_RESET;
            stat_vld_reg <= '0;
            peak_vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_wdata;
            stat_vld_reg <= stat_vld_next;
            peak_vld_reg <= peak_vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Record memories: read on accept, written back by begin or end
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_start_reg <= start_mem[req_idx];
            rd_last_reg  <= last_mem[req_idx];
            rd_peak_reg  <= peak_mem[req_idx];
            rd_slot_reg  <= slot_mem[req_idx];
            rd_full_reg  <= full_mem[req_idx];
            rd_sum_reg   <= sum_mem[req_idx];
        end
        if (wr_begin)
        begin
            // latch the start time, carry the rest of the record over
            start_mem[idx_reg] <= ts_sh_reg;
            last_mem[idx_reg]  <= eff_last;
            slot_mem[idx_reg]  <= eff_slot;
            full_mem[idx_reg]  <= eff_full;
            sum_mem[idx_reg]   <= eff_sum;
        end
        if (wr_end)
        begin
            start_mem[idx_reg] <= eff_start;
            last_mem[idx_reg]  <= sample;
            peak_mem[idx_reg]  <= peak_upd;
            slot_mem[idx_reg]  <= slot_upd;
            full_mem[idx_reg]  <= full_upd;
            sum_mem[idx_reg]   <= sum_upd;
        end
    end

    // sample ring: read the entry about to be overwritten, then replace it
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RING)
            win_rd_reg <= win_mem[win_addr];
        if (wr_end)
            win_mem[win_addr] <= sample;
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg    <= req.operation;
                    ph_reg    <= req.phase;
                    ph_ok_reg <= req_ph_ok;
                    idx_reg   <= req_idx;
                    ts_sh_reg <= req.timestamp;
                end
            end
            S_LOAD:
            begin
                last_w_reg  <= eff_last;
                peak_w_reg  <= eff_peak;
                slot_w_reg  <= eff_slot;
                full_w_reg  <= eff_full;
                sum_w_reg   <= eff_sum;
                st_sh_reg   <= eff_start;
                borrow_reg  <= 1'b0;
                dig_cnt_reg <= '0;
            end
            S_SUB:
            begin
                // advance one nibble; the difference fills from the top
                ts_sh_reg   <= ts_sh_reg >> DIG_W;
                st_sh_reg   <= st_sh_reg >> DIG_W;
                diff_reg    <= {dig_diff[DIG_W-1:0], diff_reg[TS_W-1:DIG_W]};
                borrow_reg  <= dig_diff[DIG_W];
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
            end
            S_UPD:
            begin
                last_w_reg <= sample;
                peak_w_reg <= peak_upd;
                slot_w_reg <= slot_upd;
                full_w_reg <= full_upd;
                sum_w_reg  <= sum_upd;
            end
            S_DIVINIT:
            begin
                n_reg       <= n_cur;
                rem_reg     <= '0;
                // an empty window or a bad phase reports a zero average
                dvd_reg     <= div_skip ? '0 : sum_w_reg;
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg     <= rem_step;
                dvd_reg     <= {dvd_reg[SUM_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            default:
            begin
                // S_RING and S_DONE: hold
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: frees the sequencer while the result waits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_rsp)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_reg.phase_out  <= ph_reg;
            rsp_reg.last_ticks <= ph_ok_reg ? last_w_reg : '0;
            rsp_reg.avg_ticks  <= dvd_reg[SAMP_W-1:0];
            rsp_reg.max_ticks  <= ph_ok_reg ? peak_w_reg : '0;
            rsp_reg.samples    <= ph_ok_reg ? SAMPLES_W'(n_cur) : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/plc_checker.sv =====
`timescale 1ns / 1ps
module plc_checker #(
    parameter int PHASES = 11,
    parameter int WINDOW = 120
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input plc_pkg::rsp_item_t         rsp
);
    import plc_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed or dropped while stalled");

    // one item at a time: an accepted item keeps the input closed next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input open right after an accepted item");

    // an empty window reports a zero average
    a_empty_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (WINDOW < 128) && rsp_valid && (rsp.samples == '0) |-> (rsp.avg_ticks == '0))
        else $error("nonzero average over an empty window");

    // a phase out of range reports zero statistics
    a_bad_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (32'(rsp.phase_out) >= PHASES)
        |-> (rsp.last_ticks == '0) && (rsp.avg_ticks == '0)
            && (rsp.max_ticks == '0) && (rsp.samples == '0))
        else $error("statistics reported for a phase out of range");

endmodule

bind phase_latency_profiler_core plc_checker #(
    .PHASES (PHASES),
    .WINDOW (WINDOW)
) u_plc_checker (.*);
